@@ rtl/core/ips_pkg.sv @@
// Shared types and constants for the interleaved PIFO scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none
package ips_pkg;

  localparam logic [2:0] OUT_DROP    = 3'd0;
  localparam logic [2:0] OUT_REJECT  = 3'd1;
  localparam logic [2:0] OUT_ACCEPT  = 3'd2;
  localparam logic [2:0] OUT_DEQUEUE = 3'd3;
  localparam logic [2:0] OUT_EMPTY   = 3'd4;

  localparam logic [23:0] BUDGET_RESET = 24'd1048576;
  localparam logic [23:0] BYTES_MAX    = 24'hFFFFFF;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_ACK = 2'd1,
    OP_DEQ = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] handle;
    logic [15:0] bytes;
    logic [31:0] rank;
    logic [47:0] stamp;
  } cmd_t;

  typedef struct packed {
    logic [31:0] rank;
    logic [47:0] stamp;
    logic [15:0] handle;
    logic [15:0] bytes;
  } entry_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] bytes;
  } ack_entry_t;

endpackage
`default_nettype wire

@@ rtl/core/ips_front.sv @@
// Front end: takes input items, classifies them and holds them in a two-entry queue.
// Depends on ips_pkg.
`default_nettype none
module ips_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          action,
  input  wire logic          is_ack,
  input  wire logic [15:0]   packet_handle,
  input  wire logic [15:0]   packet_bytes,
  input  wire logic [31:0]   priority_rank,
  input  wire logic [47:0]   send_stamp,
  output logic               cmd_valid,
  input  wire logic          cmd_take,
  output ips_pkg::cmd_t      cmd
);
  import ips_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       incoming;

  always_comb begin
    incoming.handle = packet_handle;
    incoming.bytes  = packet_bytes;
    incoming.rank   = priority_rank;
    incoming.stamp  = send_stamp;
    priority if (action) begin
      incoming.op = OP_DEQ;
    end else if (is_ack) begin
      incoming.op = OP_ACK;
    end else begin
      incoming.op = OP_ENQ;
    end
  end

  assign in_stall  = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_valid && cmd_take;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ips_back.sv @@
// Back end: PIFO entry memory, ack bypass FIFO, byte counts and the sequencer
// that carries out one item at a time. Depends on ips_pkg.
`default_nettype none
module ips_back #(
  parameter int QUEUE_COUNT = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int ACK_DEPTH   = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [23:0]   budget,
  input  wire logic          cmd_valid,
  output logic               cmd_take,
  input  wire ips_pkg::cmd_t cmd,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         outcome,
  output logic [15:0]        result_handle,
  output logic               last_of_run
);
  import ips_pkg::*;

  localparam int QW  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int SLW = $clog2(QUEUE_COUNT + 1);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int AW  = $clog2(QUEUE_COUNT * QUEUE_DEPTH);
  localparam int HW  = $clog2(ACK_DEPTH);
  localparam int CW  = $clog2(ACK_DEPTH + 1);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_ACK       = 13'b0000000000010,
    S_ACKD      = 13'b0000000000100,
    S_PUSH_CHK  = 13'b0000000001000,
    S_PUSH_EM   = 13'b0000000010000,
    S_INS_CHK   = 13'b0000000100000,
    S_INS_CMP   = 13'b0000001000000,
    S_INS_WR    = 13'b0000010000000,
    S_SCAN      = 13'b0000100000000,
    S_EMPTY     = 13'b0001000000000,
    S_POP       = 13'b0010000000000,
    S_SHIFT_CHK = 13'b0100000000000,
    S_SHIFT_WR  = 13'b1000000000000
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [QW-1:0] qi,
                                            input logic [FW-1:0] slot);
    addr_of = AW'(int'(qi) * QUEUE_DEPTH + int'(slot));
  endfunction

  function automatic logic [QW-1:0] next_q(input logic [QW-1:0] p);
    next_q = (p == QW'(QUEUE_COUNT - 1)) ? '0 : p + QW'(1);
  endfunction

  function automatic logic [23:0] sub_floor(input logic [23:0] a, input logic [15:0] b);
    sub_floor = (a > 24'(b)) ? a - 24'(b) : '0;
  endfunction

  // storage
  entry_t     mem [QUEUE_COUNT * QUEUE_DEPTH];
  ack_entry_t ack_mem [ACK_DEPTH];
  entry_t     rdata;
  ack_entry_t ack_rdata;

  state_t          state;
  cmd_t            cur;
  logic [QW-1:0]   q;
  logic [QW-1:0]   scan_q;
  logic [SLW-1:0]  scan_left;
  logic [FW-1:0]   idx;
  logic [FW-1:0]   fill [QUEUE_COUNT];
  logic [23:0]     used [QUEUE_COUNT];
  logic [QW-1:0]   enq_ptr;
  logic [QW-1:0]   deq_ptr;
  logic [QW-1:0]   ack_in_ptr;
  logic [QW-1:0]   ack_out_ptr;
  logic [HW-1:0]   ack_head;
  logic [HW-1:0]   ack_tail;
  logic [CW-1:0]   ack_count;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;
  logic            ack_rd_en;
  logic            ack_wr_en;

  logic            out_free;
  logic            emit;
  logic [2:0]      emit_outcome;
  logic [15:0]     emit_handle;
  logic            emit_last;

  logic [FW-1:0]   n;
  logic [24:0]     need_sum;
  logic            over_bytes;
  logic            push_out;
  logic            better;
  logic            ack_full;
  logic [24:0]     ack_sum;
  entry_t          new_entry;

  assign n          = fill[q];
  assign need_sum   = {1'b0, used[q]} + 25'(cur.bytes);
  assign over_bytes = need_sum > {1'b0, budget};
  assign push_out   = (over_bytes || n >= FW'(QUEUE_DEPTH)) && (n != '0);
  assign better     = (cur.rank < rdata.rank) ||
                      (cur.rank == rdata.rank && cur.stamp < rdata.stamp);
  assign ack_full   = ack_count >= CW'(ACK_DEPTH);
  assign ack_sum    = {1'b0, used[ack_in_ptr]} + 25'(cur.bytes);
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    new_entry.rank   = cur.rank;
    new_entry.stamp  = cur.stamp;
    new_entry.handle = cur.handle;
    new_entry.bytes  = cur.bytes;
  end

  // memory controls and result emission
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = rdata;
    ack_rd_en    = 1'b0;
    ack_wr_en    = 1'b0;
    cmd_take     = 1'b0;
    emit         = 1'b0;
    emit_outcome = OUT_EMPTY;
    emit_handle  = cur.handle;
    emit_last    = 1'b1;
    unique case (state)
      S_IDLE: begin
        cmd_take  = cmd_valid;
        ack_rd_en = cmd_valid && (cmd.op == OP_DEQ) && (ack_count != '0);
      end
      S_ACK: begin
        emit         = out_free;
        emit_outcome = ack_full ? OUT_REJECT : OUT_ACCEPT;
        ack_wr_en    = out_free && !ack_full;
      end
      S_ACKD: begin
        emit         = out_free;
        emit_outcome = OUT_DEQUEUE;
        emit_handle  = ack_rdata.handle;
      end
      S_PUSH_CHK: begin
        if (push_out) begin
          rd_en   = 1'b1;
          rd_addr = addr_of(q, n - FW'(1));
        end else if (over_bytes) begin
          emit         = out_free;
          emit_outcome = OUT_REJECT;
        end
      end
      S_PUSH_EM: begin
        emit         = out_free;
        emit_outcome = OUT_DROP;
        emit_handle  = rdata.handle;
        emit_last    = 1'b0;
      end
      S_INS_CHK: begin
        if (idx != '0) begin
          rd_en   = 1'b1;
          rd_addr = addr_of(q, idx - FW'(1));
        end
      end
      S_INS_CMP: begin
        if (better) begin
          wr_en   = 1'b1;
          wr_addr = addr_of(q, idx);
        end
      end
      S_INS_WR: begin
        emit         = out_free;
        emit_outcome = OUT_ACCEPT;
        wr_en        = out_free;
        wr_addr      = addr_of(q, idx);
        wr_data      = new_entry;
      end
      S_SCAN: begin
        if (fill[scan_q] != '0) begin
          rd_en   = 1'b1;
          rd_addr = addr_of(scan_q, '0);
        end
      end
      S_EMPTY: begin
        emit         = out_free;
        emit_outcome = OUT_EMPTY;
        emit_handle  = '0;
      end
      S_POP: begin
        emit         = out_free;
        emit_outcome = OUT_DEQUEUE;
        emit_handle  = rdata.handle;
      end
      S_SHIFT_CHK: begin
        if (idx + FW'(1) < n) begin
          rd_en   = 1'b1;
          rd_addr = addr_of(q, idx + FW'(1));
        end
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = addr_of(q, idx);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ack_wr_en) ack_mem[ack_tail] <= '{handle: cur.handle, bytes: cur.bytes};
    if (ack_rd_en) ack_rdata <= ack_mem[ack_head];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      outcome       <= emit_outcome;
      result_handle <= emit_handle;
      last_of_run   <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) cur <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      enq_ptr     <= '0;
      deq_ptr     <= '0;
      ack_in_ptr  <= '0;
      ack_out_ptr <= '0;
      ack_head    <= '0;
      ack_tail    <= '0;
      ack_count   <= '0;
      q           <= '0;
      scan_q      <= '0;
      scan_left   <= '0;
      idx         <= '0;
      for (int k = 0; k < QUEUE_COUNT; k++) begin
        fill[k] <= '0;
        used[k] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              OP_DEQ: begin
                if (ack_count != '0) begin
                  state <= S_ACKD;
                end else begin
                  scan_q    <= deq_ptr;
                  scan_left <= SLW'(QUEUE_COUNT);
                  state     <= S_SCAN;
                end
              end
              OP_ACK: state <= S_ACK;
              OP_ENQ: begin
                q     <= enq_ptr;
                state <= S_PUSH_CHK;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ACK: begin
          if (out_free) begin
            if (!ack_full) begin
              ack_tail   <= (ack_tail == HW'(ACK_DEPTH - 1)) ? '0 : ack_tail + HW'(1);
              ack_count  <= ack_count + CW'(1);
              used[ack_in_ptr] <= ack_sum[24] ? BYTES_MAX : ack_sum[23:0];
              ack_in_ptr <= next_q(ack_in_ptr);
            end
            state <= S_IDLE;
          end
        end
        S_ACKD: begin
          if (out_free) begin
            used[ack_out_ptr] <= sub_floor(used[ack_out_ptr], ack_rdata.bytes);
            ack_out_ptr <= next_q(ack_out_ptr);
            ack_head    <= (ack_head == HW'(ACK_DEPTH - 1)) ? '0 : ack_head + HW'(1);
            ack_count   <= ack_count - CW'(1);
            state       <= S_IDLE;
          end
        end
        S_PUSH_CHK: begin
          if (push_out) begin
            state <= S_PUSH_EM;
          end else if (over_bytes) begin
            if (out_free) state <= S_IDLE;
          end else begin
            idx   <= n;
            state <= S_INS_CHK;
          end
        end
        S_PUSH_EM: begin
          if (out_free) begin
            used[q] <= sub_floor(used[q], rdata.bytes);
            fill[q] <= n - FW'(1);
            state   <= S_PUSH_CHK;
          end
        end
        S_INS_CHK: begin
          state <= (idx == '0) ? S_INS_WR : S_INS_CMP;
        end
        S_INS_CMP: begin
          // entry moves down one slot while the new item ranks ahead of it
          if (better) begin
            idx   <= idx - FW'(1);
            state <= S_INS_CHK;
          end else begin
            state <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          if (out_free) begin
            fill[q] <= n + FW'(1);
            used[q] <= need_sum[23:0];
            enq_ptr <= next_q(q);
            state   <= S_IDLE;
          end
        end
        S_SCAN: begin
          deq_ptr <= next_q(scan_q);
          if (fill[scan_q] != '0) begin
            q     <= scan_q;
            state <= S_POP;
          end else if (scan_left == SLW'(1)) begin
            state <= S_EMPTY;
          end else begin
            scan_q    <= next_q(scan_q);
            scan_left <= scan_left - SLW'(1);
          end
        end
        S_EMPTY: begin
          if (out_free) state <= S_IDLE;
        end
        S_POP: begin
          if (out_free) begin
            used[q] <= sub_floor(used[q], rdata.bytes);
            idx     <= '0;
            state   <= S_SHIFT_CHK;
          end
        end
        S_SHIFT_CHK: begin
          if (idx + FW'(1) < n) begin
            state <= S_SHIFT_WR;
          end else begin
            fill[q] <= n - FW'(1);
            state   <= S_IDLE;
          end
        end
        S_SHIFT_WR: begin
          idx   <= idx + FW'(1);
          state <= S_SHIFT_CHK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/interleaved_pifo_scheduler_unit.sv @@
// Interleaved PIFO scheduler with push-out: budget register, front queue and back end.
// Depends on ips_pkg, ips_front and ips_back.
//
// Items arrive on in_valid/in_stall (action, is_ack and packet fields) and
// results leave on out_valid/out_stall; a transfer happens when valid is high
// and stall is low. Each item yields one or more results, the final one with
// last_of_run set. The budget register is written through cfg_valid/cfg_ready
// (always ready); the user must write it only while the block is idle (not enforced).
// A two-entry front queue takes items while the back end works; the back end
// runs one item at a time on a single-port-per-direction entry memory. An
// ordinary enqueue first pushes out tail entries while the queue is full or
// over its byte budget, then moves entries down to make room (insertion walks
// up from the tail); a reject comes after any push-outs. A queue dequeue scans
// the queues from the dequeue pointer and moves the remaining entries up; an
// empty dequeue scans all QUEUE_COUNT queues.
// The first result appears in the cycle after the back end decides it. A stalled
// receiver holds the output register and the back end waits on it; the front
// queue keeps accepting until both entries are taken.
// Reset clears all queues, counts and pointers at once; no clearing pass.
`default_nettype none
module interleaved_pifo_scheduler_unit #(
  parameter int QUEUE_COUNT = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int ACK_DEPTH   = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          action,
  input  wire logic          is_ack,
  input  wire logic [15:0]   packet_handle,
  input  wire logic [15:0]   packet_bytes,
  input  wire logic [31:0]   priority_rank,
  input  wire logic [47:0]   send_stamp,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         outcome,
  output logic [15:0]        result_handle,
  output logic               last_of_run,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [23:0]   queue_byte_budget
);
  import ips_pkg::*;

  logic [23:0] budget;
  logic        cmd_valid;
  logic        cmd_take;
  cmd_t        cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= BUDGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      budget <= queue_byte_budget;
    end
  end

  ips_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .is_ack        (is_ack),
    .packet_handle (packet_handle),
    .packet_bytes  (packet_bytes),
    .priority_rank (priority_rank),
    .send_stamp    (send_stamp),
    .cmd_valid     (cmd_valid),
    .cmd_take      (cmd_take),
    .cmd           (cmd)
  );

  ips_back #(
    .QUEUE_COUNT (QUEUE_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ACK_DEPTH   (ACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .budget        (budget),
    .cmd_valid     (cmd_valid),
    .cmd_take      (cmd_take),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .outcome       (outcome),
    .result_handle (result_handle),
    .last_of_run   (last_of_run)
  );

  // a push-out result is never last; the run always ends in a reject or an accept
  a_drop_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_DROP |-> !last_of_run)
    else $error("push-out result marked last");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_EMPTY |-> last_of_run && result_handle == 16'd0)
    else $error("empty result malformed");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OUT_DEQUEUE || outcome == OUT_ACCEPT ||
                  outcome == OUT_REJECT) |-> last_of_run)
    else $error("terminal result not marked last");

endmodule
`default_nettype wire
